// ===== rtl/core/dlsq_pkg.sv =====
// ----------------------------------------------------------------------------
// dlsq_pkg
// shared widths, register map, event codes and reset values of the
// dual level sensor qualifier
// ----------------------------------------------------------------------------
package dlsq_pkg;

   localparam int TimeWidth  = 32;
   localparam int CountWidth = 8;
   localparam int CsrAddrW   = 5;
   localparam int CsrDataW   = 32;
   localparam int CsrIndexW  = 3;

   // register indexes (byte address is 4 * index)
   localparam logic [CsrIndexW-1:0] RegPrequalWindow   = 3'd0;
   localparam logic [CsrIndexW-1:0] RegPrequalInterval = 3'd1;
   localparam logic [CsrIndexW-1:0] RegPrequalNeeded   = 3'd2;
   localparam logic [CsrIndexW-1:0] RegSettleTime      = 3'd3;
   localparam logic [CsrIndexW-1:0] RegDebounceWindow  = 3'd4;
   localparam logic [CsrIndexW-1:0] RegDebounceInterval = 3'd5;
   localparam logic [CsrIndexW-1:0] RegDebounceNeeded  = 3'd6;

   // register reset values
   localparam logic [15:0] RstPrequalWindow    = 16'd30;
   localparam logic [15:0] RstPrequalInterval  = 16'd10;
   localparam logic [7:0]  RstPrequalNeeded    = 8'd3;
   localparam logic [15:0] RstSettleTime       = 16'd60;
   localparam logic [15:0] RstDebounceWindow   = 16'd1200;
   localparam logic [15:0] RstDebounceInterval = 16'd60;
   localparam logic [7:0]  RstDebounceNeeded   = 8'd4;

   typedef enum logic [2:0] {
      EV_NONE             = 3'd0,
      EV_PREQUAL_START    = 3'd1,
      EV_PREQUAL_TIMEOUT  = 3'd2,
      EV_PREQUAL_PASS     = 3'd3,
      EV_SETTLED          = 3'd4,
      EV_DEBOUNCE_TIMEOUT = 3'd5,
      EV_BOTH_DONE        = 3'd6
   } event_type;

   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      sat_inc = (v == CountMax) ? v : v + 1'b1;
   endfunction

endpackage

// ===== rtl/core/dual_level_sensor_qualifier.sv =====
// ----------------------------------------------------------------------------
// dual_level_sensor_qualifier
// four-phase qualification of two active-low level sensors, one word per
// sample, with an apb-style register port for windows, intervals, settle time and counts
// ----------------------------------------------------------------------------
// path: a result word is registered; the request word is taken into the input
// register, then the state update writes the result register once it is free
// throughput: one word per cycle while results are drained, limited by the single state
// update stage; a held result stops the next word once the input register is full
// reset: synchronous, active high; phase returns to idle, all counts, done flags
// and timestamps clear and the registers take their documented defaults
// ----------------------------------------------------------------------------
module dual_level_sensor_qualifier
   import dlsq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [TimeWidth-1:0]     req_now_seconds,
   input  logic                     req_level_one_low,
   input  logic                     req_level_two_low,
   input  logic                     req_consumer_busy,
   input  logic                     req_abort_request,

   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_event_code,
   output logic                     rsp_one_done_now,
   output logic                     rsp_two_done_now,
   output logic                     rsp_one_ok,
   output logic                     rsp_two_ok,
   output logic [1:0]               rsp_phase_now,
   output logic [CountWidth-1:0]    rsp_prequal_count_now,
   output logic [CountWidth-1:0]    rsp_one_count_now,
   output logic [CountWidth-1:0]    rsp_two_count_now,

   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CsrAddrW-1:0]      paddr,
   input  logic [CsrDataW-1:0]      pwdata,
   output logic [CsrDataW-1:0]      prdata,
   output logic                     pready
);

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_PREQUAL  = 2'd1,
      PH_SETTLE   = 2'd2,
      PH_DEBOUNCE = 2'd3
   } phase_type;

   // configuration registers
   logic [15:0]           prequal_window_ff;
   logic [15:0]           prequal_interval_ff;
   logic [7:0]            prequal_needed_ff;
   logic [15:0]           settle_time_ff;
   logic [15:0]           debounce_window_ff;
   logic [15:0]           debounce_interval_ff;
   logic [7:0]            debounce_needed_ff;

   // input register
   logic                  in_valid_ff;
   logic [TimeWidth-1:0]  in_now_ff;
   logic                  in_low_one_ff;
   logic                  in_low_two_ff;
   logic                  in_busy_ff;
   logic                  in_abort_ff;

   // process state
   phase_type             phase_ff, phase_in;
   logic [TimeWidth-1:0]  phase_start_ff, phase_start_in;
   logic [TimeWidth-1:0]  last_sample_ff, last_sample_in;
   logic [CountWidth-1:0] prequal_count_ff, prequal_count_in;
   logic [CountWidth-1:0] one_count_ff, one_count_in;
   logic [CountWidth-1:0] two_count_ff, two_count_in;
   logic                  one_done_ff, one_done_in;
   logic                  two_done_ff, two_done_in;

   // result register
   logic                  out_valid_ff;
   event_type             event_ff, event_in;
   logic                  one_done_now_ff, one_done_now_in;
   logic                  two_done_now_ff, two_done_now_in;
   logic                  one_ok_ff, one_ok_in;
   logic                  two_ok_ff, two_ok_in;

   // handshake and flow
   logic                  out_free;
   logic                  advance;
   logic                  req_take;
   logic                  csr_write;
   logic [CsrIndexW-1:0]  csr_index;

   // working values of the update
   logic [TimeWidth-1:0]  elapsed;
   logic [TimeWidth-1:0]  since_sample;
   logic                  any_low;
   logic                  ok_latched;
   logic                  ok_one_latch;
   logic                  ok_two_latch;
   logic [CountWidth-1:0] prequal_next;
   logic [CountWidth-1:0] one_next;
   logic [CountWidth-1:0] two_next;

   // result register frees when empty or being drained this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[CsrAddrW-1:2];
   assign pready    = 1'b1;

   always_comb begin
      case (csr_index)
         RegPrequalWindow:    prdata = {16'd0, prequal_window_ff};
         RegPrequalInterval:  prdata = {16'd0, prequal_interval_ff};
         RegPrequalNeeded:    prdata = {24'd0, prequal_needed_ff};
         RegSettleTime:       prdata = {16'd0, settle_time_ff};
         RegDebounceWindow:   prdata = {16'd0, debounce_window_ff};
         RegDebounceInterval: prdata = {16'd0, debounce_interval_ff};
         RegDebounceNeeded:   prdata = {24'd0, debounce_needed_ff};
         default:             prdata = '0;
      endcase
   end

   // one pass of the qualification step on the registered word
   always_comb begin
      phase_in         = phase_ff;
      phase_start_in   = phase_start_ff;
      last_sample_in   = last_sample_ff;
      prequal_count_in = prequal_count_ff;
      one_count_in     = one_count_ff;
      two_count_in     = two_count_ff;
      one_done_in      = one_done_ff;
      two_done_in      = two_done_ff;
      event_in         = EV_NONE;
      one_done_now_in  = 1'b0;
      two_done_now_in  = 1'b0;
      ok_latched       = 1'b0;
      ok_one_latch     = 1'b0;
      ok_two_latch     = 1'b0;
      any_low          = in_low_one_ff || in_low_two_ff;

      // abort wipes the process before the step proper
      if (in_abort_ff) begin
         phase_in         = PH_IDLE;
         phase_start_in   = '0;
         last_sample_in   = '0;
         prequal_count_in = '0;
         one_count_in     = '0;
         two_count_in     = '0;
         one_done_in      = 1'b0;
         two_done_in      = 1'b0;
      end

      elapsed      = in_now_ff - phase_start_in;
      since_sample = in_now_ff - last_sample_in;
      prequal_next = sat_inc(prequal_count_in);
      one_next     = sat_inc(one_count_in);
      two_next     = sat_inc(two_count_in);

      // busy consumer: step skipped, state reported as it stands
      if (!in_busy_ff) begin
         case (phase_in)
            PH_IDLE: begin
               if (any_low) begin
                  phase_in         = PH_PREQUAL;
                  phase_start_in   = in_now_ff;
                  last_sample_in   = in_now_ff;
                  prequal_count_in = 8'd1;
                  event_in         = EV_PREQUAL_START;
               end
            end
            PH_PREQUAL: begin
               if (elapsed > {16'd0, prequal_window_ff}) begin
                  phase_in         = PH_IDLE;
                  phase_start_in   = '0;
                  last_sample_in   = '0;
                  prequal_count_in = '0;
                  one_count_in     = '0;
                  two_count_in     = '0;
                  one_done_in      = 1'b0;
                  two_done_in      = 1'b0;
                  event_in         = EV_PREQUAL_TIMEOUT;
               end else if (since_sample >= {16'd0, prequal_interval_ff}) begin
                  last_sample_in = in_now_ff;
                  if (any_low) begin
                     prequal_count_in = prequal_next;
                     if (prequal_next >= prequal_needed_ff) begin
                        phase_in       = PH_SETTLE;
                        phase_start_in = in_now_ff;
                        event_in       = EV_PREQUAL_PASS;
                     end
                  end else begin
                     prequal_count_in = '0;
                  end
               end
            end
            PH_SETTLE: begin
               if (elapsed >= {16'd0, settle_time_ff}) begin
                  phase_in       = PH_DEBOUNCE;
                  phase_start_in = in_now_ff;
                  last_sample_in = in_now_ff;
                  one_count_in   = '0;
                  two_count_in   = '0;
                  one_done_in    = 1'b0;
                  two_done_in    = 1'b0;
                  event_in       = EV_SETTLED;
               end
            end
            PH_DEBOUNCE: begin
               if (elapsed > {16'd0, debounce_window_ff} || (one_done_in && two_done_in)) begin
                  // ok flags keep the per-sensor outcome of the ended run
                  ok_latched       = 1'b1;
                  ok_one_latch     = one_done_in;
                  ok_two_latch     = two_done_in;
                  event_in         = (elapsed > {16'd0, debounce_window_ff}) ?
                                     EV_DEBOUNCE_TIMEOUT : EV_BOTH_DONE;
                  phase_in         = PH_IDLE;
                  phase_start_in   = '0;
                  last_sample_in   = '0;
                  prequal_count_in = '0;
                  one_count_in     = '0;
                  two_count_in     = '0;
                  one_done_in      = 1'b0;
                  two_done_in      = 1'b0;
               end else if (since_sample >= {16'd0, debounce_interval_ff}) begin
                  last_sample_in = in_now_ff;
                  if (!one_done_in) begin
                     if (in_low_one_ff) begin
                        one_count_in = one_next;
                        if (one_next >= debounce_needed_ff) begin
                           one_done_in     = 1'b1;
                           one_done_now_in = 1'b1;
                        end
                     end else begin
                        one_count_in = '0;
                     end
                  end
                  if (!two_done_in) begin
                     if (in_low_two_ff) begin
                        two_count_in = two_next;
                        if (two_next >= debounce_needed_ff) begin
                           two_done_in     = 1'b1;
                           two_done_now_in = 1'b1;
                        end
                     end else begin
                        two_count_in = '0;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      one_ok_in = ok_latched ? ok_one_latch : one_done_in;
      two_ok_in = ok_latched ? ok_two_latch : two_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prequal_window_ff    <= RstPrequalWindow;
         prequal_interval_ff  <= RstPrequalInterval;
         prequal_needed_ff    <= RstPrequalNeeded;
         settle_time_ff       <= RstSettleTime;
         debounce_window_ff   <= RstDebounceWindow;
         debounce_interval_ff <= RstDebounceInterval;
         debounce_needed_ff   <= RstDebounceNeeded;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         phase_ff             <= PH_IDLE;
         phase_start_ff       <= '0;
         last_sample_ff       <= '0;
         prequal_count_ff     <= '0;
         one_count_ff         <= '0;
         two_count_ff         <= '0;
         one_done_ff          <= 1'b0;
         two_done_ff          <= 1'b0;
      end else begin
         // register writes on the access phase
         if (csr_write) begin
            case (csr_index)
               RegPrequalWindow:    prequal_window_ff    <= pwdata[15:0];
               RegPrequalInterval:  prequal_interval_ff  <= pwdata[15:0];
               RegPrequalNeeded:    prequal_needed_ff    <= pwdata[7:0];
               RegSettleTime:       settle_time_ff       <= pwdata[15:0];
               RegDebounceWindow:   debounce_window_ff   <= pwdata[15:0];
               RegDebounceInterval: debounce_interval_ff <= pwdata[15:0];
               RegDebounceNeeded:   debounce_needed_ff   <= pwdata[7:0];
               default: begin
               end
            endcase
         end

         // input register
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         // state update and result capture
         if (advance) begin
            out_valid_ff     <= 1'b1;
            phase_ff         <= phase_in;
            phase_start_ff   <= phase_start_in;
            last_sample_ff   <= last_sample_in;
            prequal_count_ff <= prequal_count_in;
            one_count_ff     <= one_count_in;
            two_count_ff     <= two_count_in;
            one_done_ff      <= one_done_in;
            two_done_ff      <= two_done_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end

      // payload, no reset needed
      if (req_take) begin
         in_now_ff     <= req_now_seconds;
         in_low_one_ff <= req_level_one_low;
         in_low_two_ff <= req_level_two_low;
         in_busy_ff    <= req_consumer_busy;
         in_abort_ff   <= req_abort_request;
      end
      if (advance) begin
         event_ff        <= event_in;
         one_done_now_ff <= one_done_now_in;
         two_done_now_ff <= two_done_now_in;
         one_ok_ff       <= one_ok_in;
         two_ok_ff       <= two_ok_in;
      end
   end

   // result word: counts and phase are the state after the step
   assign rsp_valid             = out_valid_ff;
   assign rsp_event_code        = event_ff;
   assign rsp_one_done_now      = one_done_now_ff;
   assign rsp_two_done_now      = two_done_now_ff;
   assign rsp_one_ok            = one_ok_ff;
   assign rsp_two_ok            = two_ok_ff;
   assign rsp_phase_now         = phase_ff;
   assign rsp_prequal_count_now = prequal_count_ff;
   assign rsp_one_count_now     = one_count_ff;
   assign rsp_two_count_now     = two_count_ff;

endmodule
